// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the lorentz_boost_matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lbm_pkg.sv -----
// ----------------------------------------------------------------------------
// lbm_pkg
// Beat types, widths and saturation limits of the Lorentz boost pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 48;

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] beta_x;
    logic signed [IN_W-1:0] beta_y;
    logic signed [IN_W-1:0] beta_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] entry_xx;
    logic signed [OUT_W-1:0] entry_yy;
    logic signed [OUT_W-1:0] entry_zz;
    logic signed [OUT_W-1:0] entry_xy;
    logic signed [OUT_W-1:0] entry_xz;
    logic signed [OUT_W-1:0] entry_yz;
    logic signed [OUT_W-1:0] entry_xt;
    logic signed [OUT_W-1:0] entry_yt;
    logic signed [OUT_W-1:0] entry_zt;
    logic signed [OUT_W-1:0] entry_tt;
    logic                    invalid;
  } out_beat_t;

  typedef struct packed {
    logic en;
    logic valid;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lbm_in_if.sv -----
// ----------------------------------------------------------------------------
// lbm_in_if
// Velocity beat channel: valid, ready and the three beta components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbm_in_if;
  import lbm_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lbm_out_if.sv -----
// ----------------------------------------------------------------------------
// lbm_out_if
// Matrix beat channel: valid, ready and the ten entries plus invalid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbm_out_if;
  import lbm_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lbm_sqrt.sv -----
// ----------------------------------------------------------------------------
// lbm_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbm_sqrt #(
  parameter int unsigned W  = 64,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lbm_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  rad_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W/2-1:0] root_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned N  = W / 2;
  localparam int unsigned RW = N + 2;

  logic          vld  [0:N];
  logic [N-1:0]  root [0:N];
  logic [SW-1:0] side [0:N];
  logic [RW-1:0] rem  [0:N-1];
  logic [W-1:0]  rad  [0:N-1];

  assign vld[0]  = ctl_i.valid;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign rem[0]  = '0;
  assign rad[0]  = rad_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    assign cur   = {rem[k], rad[k][W-1:W-2]};
    assign trial = (RW+2)'({root[k], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        root[k+1] <= {root[k][N-2:0], ge};
        side[k+1] <= side[k];
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          rem[k+1] <= ge ? RW'(cur - trial) : RW'(cur);
          rad[k+1] <= rad[k] << 2;
        end
      end
    end
  end

  assign valid_o = vld[N];
  assign root_o  = root[N];
  assign side_o  = side[N];

endmodule

`default_nettype wire

// ----- hw/rtl/lbm_div.sv -----
// ----------------------------------------------------------------------------
// lbm_div
// Pipelined restoring divider, one numerator bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbm_div #(
  parameter int unsigned NW = 62,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 61,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lbm_pkg::ctl_t ctl_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld  [0:NW];
  logic [QW-1:0] quo  [0:NW];
  logic [DW-1:0] den  [0:NW];
  logic [SW-1:0] side [0:NW];
  logic [DW-1:0] rem  [0:NW-1];
  logic [NW-1:0] num  [0:NW-1];

  assign vld[0]  = ctl_i.valid;
  assign quo[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;
  assign rem[0]  = '0;
  assign num[0]  = num_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem[k], num[k][NW-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        quo[k+1]  <= {quo[k][QW-2:0], ge};
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end

    if (k < NW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          rem[k+1] <= ge ? DW'(trial - {1'b0, den[k]}) : trial[DW-1:0];
          num[k+1] <= num[k] << 1;
        end
      end
    end
  end

  assign valid_o = vld[NW];
  assign quo_o   = quo[NW];
  assign side_o  = side[NW];

endmodule

`default_nettype wire

// ----- hw/rtl/lbm_mul.sv -----
// ----------------------------------------------------------------------------
// lbm_mul
// Multi-lane wide multiplier: four half-width partial products, then two
// registered add levels. Three stages, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbm_mul #(
  parameter int unsigned LANES = 9,
  parameter int unsigned AW    = 61,
  parameter int unsigned BW    = 60,
  parameter int unsigned SW    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbm_pkg::ctl_t                 ctl_i,
  input  logic [LANES-1:0][AW-1:0]      a_i,
  input  logic [LANES-1:0][BW-1:0]      b_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [LANES-1:0][AW+BW-1:0]   prod_o,
  output logic [SW-1:0]                 side_o
);

  localparam int unsigned HA = (AW + 1) / 2;
  localparam int unsigned LA = AW - HA;
  localparam int unsigned HB = (BW + 1) / 2;
  localparam int unsigned LB = BW - HB;
  localparam int unsigned PW = AW + BW;

  logic                        v1_q, v2_q, v3_q;
  logic [LANES-1:0][HA+HB-1:0] pll_q;
  logic [LANES-1:0][HA+LB-1:0] plh_q;
  logic [LANES-1:0][LA+HB-1:0] phl_q;
  logic [LANES-1:0][LA+LB-1:0] phh_q;
  logic [LANES-1:0][PW-1:0]    s1_q, s2_q, prod_q;
  logic [SW-1:0]               side1_q, side2_q, side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int l = 0; l < LANES; l++) begin
        pll_q[l]  <= a_i[l][HA-1:0]  * b_i[l][HB-1:0];
        plh_q[l]  <= a_i[l][HA-1:0]  * b_i[l][BW-1:HB];
        phl_q[l]  <= a_i[l][AW-1:HA] * b_i[l][HB-1:0];
        phh_q[l]  <= a_i[l][AW-1:HA] * b_i[l][BW-1:HB];
        s1_q[l]   <= PW'(pll_q[l]) + (PW'(plh_q[l]) << HB);
        s2_q[l]   <= (PW'(phl_q[l]) << HA) + (PW'(phh_q[l]) << (HA + HB));
        prod_q[l] <= s1_q[l] + s2_q[l];
      end
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
    end
  end

  assign valid_o = v3_q;
  assign prod_o  = prod_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lorentz_boost_matrix.sv -----
// ----------------------------------------------------------------------------
// lorentz_boost_matrix
// Streaming 4x4 Lorentz boost matrix from a velocity vector, fixed point.
//
//   channel  dir  payload                                  beat
//   in_i     in   beta_x, beta_y, beta_z (32b signed)      one velocity
//   out_o    out  ten entries (48b signed), invalid        one matrix
//
// Most of the pipeline depth lies in the root and the two dividers, each of
// which resolves one bit per stage.
// A new beat is taken every cycle while the output register is free or drained.
// Reset clears only the valid bits of each stage.
// A stalled output freezes every stage in place; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lorentz_boost_matrix #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbm_in_if.sink     in_i,
  lbm_out_if.source  out_o
);
  import lbm_pkg::*;

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned M2W   = 2 * F;
  localparam int unsigned RADW  = 2 * F + 4;
  localparam int unsigned SQW   = RADW / 2;
  localparam int unsigned GW    = 2 * F + 1;
  localparam int unsigned NW1   = 2 * F + 2;
  localparam int unsigned NW2   = 2 * F + 1;
  localparam int unsigned DW2   = 2 * F + 2;
  localparam int unsigned PW    = GW + M2W;
  localparam int unsigned LANES = 9;

  localparam logic [63:0]      ONE2     = 64'd1 << M2W;
  localparam logic [GW-1:0]    ONE_G    = GW'(1) << F;
  localparam logic [DW2-1:0]   ONE_D    = DW2'(1) << F;
  localparam logic [OUT_W-1:0] ONE_O    = OUT_W'(1) << F;
  localparam logic [RADW-1:0]  RAD_SAFE = RADW'(1) << (M2W + 2);
  localparam logic [NW1-1:0]   NUM1     = NW1'(1) << (M2W + 1);
  localparam logic [NW2-1:0]   NUM2     = NW2'(1) << M2W;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  inv;
    logic [2:0][M2W-1:0]   sq;
    logic [2:0][M2W-1:0]   cr;
    logic [2:0][F-1:0]     mi;
  } side_t;

  typedef struct packed {
    side_t         sd;
    logic [GW-1:0] g;
  } side_g_t;

  typedef struct packed {
    logic [2:0]    neg;
    logic          inv;
    logic [GW-1:0] g;
  } side_m_t;

  function automatic logic [OUT_W-1:0] sat_entry(input logic [PW-1:0] q,
                                                 input logic neg,
                                                 input logic [OUT_W-1:0] add);
    logic [OUT_W:0]   s;
    logic [OUT_W-1:0] r;
    s = {1'b0, q[OUT_W-1:0]} + {1'b0, add};
    if (q > PW'(NEG_MAX)) begin
      r = neg ? NEG_MAX : POS_MAX;
    end else if (neg) begin
      r = -q[OUT_W-1:0];
    end else if (s > {1'b0, POS_MAX}) begin
      r = POS_MAX;
    end else begin
      r = s[OUT_W-1:0];
    end
    return r;
  endfunction

  logic adv;
  logic out_valid_q;
  out_beat_t out_q, out_d;

  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Magnitude and sign of each component
  logic [2:0][IN_W-1:0] beta, mag_d;
  logic [2:0]           neg_d;

  always_comb begin
    beta[0] = in_i.data.beta_x;
    beta[1] = in_i.data.beta_y;
    beta[2] = in_i.data.beta_z;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = beta[i][IN_W-1];
      mag_d[i] = neg_d[i] ? IN_W'(-beta[i]) : beta[i];
    end
  end

  logic                  v0_q, v1_q, v2_q, v3_q;
  logic [2:0][IN_W-1:0]  mag0_q;
  logic [2:0]            neg0_q, neg1_q, neg2_q;
  logic [2:0][63:0]      sq1_q;
  logic [2:0][M2W-1:0]   cr1_q, cr2_q, sq2_q;
  logic [2:0][F-1:0]     mi1_q, mi2_q;
  logic [63:0]           b2_q;
  logic [63:0]           d3;
  logic                  inv3;
  logic [RADW-1:0]       rad3_q;
  side_t                 side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign inv3 = b2_q >= ONE2;
  assign d3   = ONE2 - b2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag0_q <= mag_d;
      neg0_q <= neg_d;
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= mag0_q[i] * mag0_q[i];
        mi1_q[i] <= mag0_q[i][F-1:0];
        sq2_q[i] <= sq1_q[i][M2W-1:0];
      end
      cr1_q[0] <= mag0_q[0][F-1:0] * mag0_q[1][F-1:0];
      cr1_q[1] <= mag0_q[0][F-1:0] * mag0_q[2][F-1:0];
      cr1_q[2] <= mag0_q[1][F-1:0] * mag0_q[2][F-1:0];
      neg1_q   <= neg0_q;
      b2_q     <= sq1_q[0] + sq1_q[1] + sq1_q[2];
      cr2_q    <= cr1_q;
      mi2_q    <= mi1_q;
      neg2_q   <= neg1_q;
      rad3_q       <= inv3 ? RAD_SAFE : (RADW'(d3[M2W:0]) << 2);
      side3_q.neg  <= neg2_q;
      side3_q.inv  <= inv3;
      side3_q.sq   <= sq2_q;
      side3_q.cr   <= cr2_q;
      side3_q.mi   <= mi2_q;
    end
  end

  ctl_t ctl;
  assign ctl.en    = adv;
  assign ctl.valid = v3_q;

  // s = floor(sqrt(4*(1 - beta2)))
  logic           v_s;
  logic [SQW-1:0] s_root;
  side_t          side_s;

  lbm_sqrt #(.W(RADW), .SW($bits(side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .rad_i   (rad3_q),
    .side_i  (side3_q),
    .valid_o (v_s),
    .root_o  (s_root),
    .side_o  (side_s)
  );

  // gamma = 2^(2F+1) / s
  ctl_t          ctl_d1;
  logic          v_d1;
  logic [GW-1:0] g_d1;
  side_t         side_d1;

  assign ctl_d1.en    = adv;
  assign ctl_d1.valid = v_s;

  lbm_div #(.NW(NW1), .DW(SQW), .QW(GW), .SW($bits(side_t))) u_div_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_d1),
    .num_i   (NUM1),
    .den_i   (s_root),
    .side_i  (side_s),
    .valid_o (v_d1),
    .quo_o   (g_d1),
    .side_o  (side_d1)
  );

  logic           v4_q;
  logic [DW2-1:0] den4_q;
  side_g_t        sg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v_d1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den4_q   <= DW2'(g_d1) + ONE_D;
      sg4_q.sd <= side_d1;
      sg4_q.g  <= g_d1;
    end
  end

  // 2^(2F) / (1 + gamma)
  ctl_t         ctl_d2;
  logic         v_d2;
  logic [F-1:0] q_d2;
  side_g_t      sg_d2;

  assign ctl_d2.en    = adv;
  assign ctl_d2.valid = v4_q;

  lbm_div #(.NW(NW2), .DW(DW2), .QW(F), .SW($bits(side_g_t))) u_div_bgamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_d2),
    .num_i   (NUM2),
    .den_i   (den4_q),
    .side_i  (sg4_q),
    .valid_o (v_d2),
    .quo_o   (q_d2),
    .side_o  (sg_d2)
  );

  logic          v5_q;
  logic [GW-1:0] bg5_q;
  side_g_t       sg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v_d2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bg5_q <= sg_d2.g - ONE_G + GW'(q_d2);
      sg5_q <= sg_d2;
    end
  end

  // Nine products: bgamma * bi*bj and gamma * bi
  ctl_t                      ctl_m;
  logic [LANES-1:0][GW-1:0]  mul_a;
  logic [LANES-1:0][M2W-1:0] mul_b;
  side_m_t                   side_m_in, side_m;
  logic                      v_m;
  logic [LANES-1:0][PW-1:0]  prod;

  assign ctl_m.en    = adv;
  assign ctl_m.valid = v5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_a[i]   = bg5_q;
      mul_b[i]   = sg5_q.sd.sq[i];
      mul_a[i+3] = bg5_q;
      mul_b[i+3] = sg5_q.sd.cr[i];
      mul_a[i+6] = sg5_q.g;
      mul_b[i+6] = M2W'(sg5_q.sd.mi[i]);
    end
    side_m_in.neg = sg5_q.sd.neg;
    side_m_in.inv = sg5_q.sd.inv;
    side_m_in.g   = sg5_q.g;
  end

  lbm_mul #(.LANES(LANES), .AW(GW), .BW(M2W), .SW($bits(side_m_t))) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_m),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .side_i  (side_m_in),
    .valid_o (v_m),
    .prod_o  (prod),
    .side_o  (side_m)
  );

  // Scale, sign and saturate; all entries are zeroed on an invalid beat
  always_comb begin
    out_d.entry_xx = sat_entry(prod[0] >> M2W, 1'b0, ONE_O);
    out_d.entry_yy = sat_entry(prod[1] >> M2W, 1'b0, ONE_O);
    out_d.entry_zz = sat_entry(prod[2] >> M2W, 1'b0, ONE_O);
    out_d.entry_xy = sat_entry(prod[3] >> M2W, side_m.neg[0] ^ side_m.neg[1], '0);
    out_d.entry_xz = sat_entry(prod[4] >> M2W, side_m.neg[0] ^ side_m.neg[2], '0);
    out_d.entry_yz = sat_entry(prod[5] >> M2W, side_m.neg[1] ^ side_m.neg[2], '0);
    out_d.entry_xt = sat_entry(prod[6] >> F, side_m.neg[0], '0);
    out_d.entry_yt = sat_entry(prod[7] >> F, side_m.neg[1], '0);
    out_d.entry_zt = sat_entry(prod[8] >> F, side_m.neg[2], '0);
    out_d.entry_tt = (side_m.g > POS_MAX) ? POS_MAX : OUT_W'(side_m.g);
    out_d.invalid  = 1'b0;
    if (side_m.inv) begin
      out_d         = '0;
      out_d.invalid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_m) begin
      out_q <= out_d;
    end
  end

  `ASSERT_IMPLY(a_inv_zero, clk_i, rst_ni, out_o.valid && out_o.data.invalid, out_o.data.entry_tt == '0 && out_o.data.entry_xy == '0, "entries not cleared on invalid beat")
  `ASSERT_IMPLY(a_gamma_ge_one, clk_i, rst_ni, out_o.valid && !out_o.data.invalid, !out_o.data.entry_tt[OUT_W-1] && out_o.data.entry_tt >= ONE_O, "gamma below one")
  `ASSERT_IMPLY(a_diag_ge_one, clk_i, rst_ni, out_o.valid && !out_o.data.invalid, !out_o.data.entry_xx[OUT_W-1] && out_o.data.entry_xx >= ONE_O, "diagonal entry below one")
  `ASSERT_IMPLY(a_root_nonzero, clk_i, rst_ni, v_s, s_root != '0, "zero divisor into gamma divider")
  `ASSERT_NEXT(a_front_inv, clk_i, rst_ni, adv && v2_q && b2_q >= ONE2, v3_q && side3_q.inv, "superluminal beat not flagged")

endmodule

`default_nettype wire
